// ===== rtl/hcb_pkg.sv =====
// hcb_pkg: shared types and constants for the huffman code builder/encoder
// no dependencies; used by every rtl file but hcb_if through scoped names
`default_nettype none
package hcb_pkg;

	localparam int CODE_FIELD_BITS = 32;
	localparam int LEN_FIELD_BITS  = 6;

	// request modes
	localparam logic [1:0] MODE_COUNT  = 2'd0;
	localparam logic [1:0] MODE_BUILD  = 2'd1;
	localparam logic [1:0] MODE_ENCODE = 2'd2;

	// code table status
	typedef enum logic [1:0] {
		TS_NONE = 2'd0,
		TS_OK   = 2'd1,
		TS_LONG = 2'd2
	} tab_status_t;

	// result error codes
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_NO_CODE  = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG = 2'd2;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CNT_RD,
		OP_CNT_WR,
		OP_ENC_RD,
		OP_ENC_OUT,
		OP_B_INIT,
		OP_SCAN_RD,
		OP_SCAN_PUSH,
		OP_SCAN_NEXT,
		OP_SW_RD,
		OP_SW_MOVE,
		OP_SW_PUT,
		OP_P_RD0,
		OP_P_RDL,
		OP_P_CAP,
		OP_SK_RL,
		OP_SK_RR,
		OP_SK_STEP,
		OP_SAVE_A,
		OP_MERGE,
		OP_W_RD0,
		OP_W_ROOT,
		OP_W_POP,
		OP_W_EXAM,
		OP_W_ONE,
		OP_W_ZERO,
		OP_B_DONE
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_ENC_RD,
		ST_ENC_OUT,
		ST_B_INIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_NEXT,
		ST_SW_RD,
		ST_SW_CMP,
		ST_M_CHK,
		ST_P_RD0,
		ST_P_RDL,
		ST_P_CAP,
		ST_SK_RL,
		ST_SK_RR,
		ST_SK_STEP,
		ST_SAVE_A,
		ST_MERGE,
		ST_W_RD0,
		ST_W_ROOT,
		ST_W_POP,
		ST_W_EXAM,
		ST_W_ONE,
		ST_W_ZERO,
		ST_B_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_ready;
	} cmd_t;

	typedef struct packed {
		logic       in_fire;
		logic [1:0] in_mode;
		logic       cnt_nz;
		logic       scan_last;
		logic       idx_zero;
		logic       sw_up;
		logic       sk_move;
		logic       fill_gt1;
		logic       fill_zero;
		logic       sp_zero;
		logic       is_leaf;
		logic       out_full;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/hcb_if.sv =====
// hcb_in_if / hcb_out_if: valid-ready channels for requests and results
// no dependencies
`default_nettype none
interface hcb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] symbol;
	modport source (output valid, output mode, output symbol, input ready);
	modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface hcb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_bits;
	logic [5:0]  code_length;
	logic [1:0]  error;
	modport source (output valid, output code_bits, output code_length, output error,
		input ready);
	modport sink (input valid, input code_bits, input code_length, input error,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/hcb_ctrl.sv =====
// hcb_ctrl: sequencer for count, encode and the heap based code build
// depends on hcb_pkg
`default_nettype none
module hcb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hcb_pkg::sts_t sts,
	output hcb_pkg::cmd_t      cmd
);

	hcb_pkg::state_t state_q, state_d;
	logic in_merge_q;
	logic pop_b_q;

	// state and context registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hcb_pkg::ST_IDLE;
			in_merge_q <= 1'b0;
			pop_b_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hcb_pkg::ST_B_INIT) in_merge_q <= 1'b0;
			if (state_q == hcb_pkg::ST_MERGE) in_merge_q <= 1'b1;
			if (state_q == hcb_pkg::ST_M_CHK) pop_b_q <= 1'b0;
			if (state_q == hcb_pkg::ST_SAVE_A) pop_b_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hcb_pkg::ST_IDLE: begin
				if (sts.in_fire) begin
					case (sts.in_mode)
						hcb_pkg::MODE_COUNT:  state_d = hcb_pkg::ST_CNT_RD;
						hcb_pkg::MODE_BUILD:  state_d = hcb_pkg::ST_B_INIT;
						hcb_pkg::MODE_ENCODE: state_d = hcb_pkg::ST_ENC_RD;
						default:              state_d = hcb_pkg::ST_IDLE;
					endcase
				end
			end
			hcb_pkg::ST_CNT_RD:  state_d = hcb_pkg::ST_CNT_WR;
			hcb_pkg::ST_CNT_WR:  state_d = hcb_pkg::ST_IDLE;
			hcb_pkg::ST_ENC_RD:  state_d = hcb_pkg::ST_ENC_OUT;
			hcb_pkg::ST_ENC_OUT: if (!sts.out_full) state_d = hcb_pkg::ST_IDLE;
			hcb_pkg::ST_B_INIT:  state_d = hcb_pkg::ST_SCAN_RD;
			hcb_pkg::ST_SCAN_RD: state_d = hcb_pkg::ST_SCAN_CHK;
			hcb_pkg::ST_SCAN_CHK:
				state_d = sts.cnt_nz ? hcb_pkg::ST_SW_RD : hcb_pkg::ST_SCAN_NEXT;
			hcb_pkg::ST_SCAN_NEXT:
				state_d = sts.scan_last ? hcb_pkg::ST_M_CHK : hcb_pkg::ST_SCAN_RD;
			hcb_pkg::ST_SW_RD: begin
				if (sts.idx_zero)
					state_d = in_merge_q ? hcb_pkg::ST_M_CHK : hcb_pkg::ST_SCAN_NEXT;
				else
					state_d = hcb_pkg::ST_SW_CMP;
			end
			hcb_pkg::ST_SW_CMP: begin
				if (sts.sw_up)
					state_d = hcb_pkg::ST_SW_RD;
				else
					state_d = in_merge_q ? hcb_pkg::ST_M_CHK : hcb_pkg::ST_SCAN_NEXT;
			end
			hcb_pkg::ST_M_CHK: begin
				if (sts.fill_gt1)
					state_d = hcb_pkg::ST_P_RD0;
				else if (sts.fill_zero)
					state_d = hcb_pkg::ST_B_DONE;
				else
					state_d = hcb_pkg::ST_W_RD0;
			end
			hcb_pkg::ST_P_RD0:  state_d = hcb_pkg::ST_P_RDL;
			hcb_pkg::ST_P_RDL:  state_d = hcb_pkg::ST_P_CAP;
			hcb_pkg::ST_P_CAP:  state_d = hcb_pkg::ST_SK_RL;
			hcb_pkg::ST_SK_RL:  state_d = hcb_pkg::ST_SK_RR;
			hcb_pkg::ST_SK_RR:  state_d = hcb_pkg::ST_SK_STEP;
			hcb_pkg::ST_SK_STEP: begin
				if (sts.sk_move)
					state_d = hcb_pkg::ST_SK_RL;
				else
					state_d = pop_b_q ? hcb_pkg::ST_MERGE : hcb_pkg::ST_SAVE_A;
			end
			hcb_pkg::ST_SAVE_A: state_d = hcb_pkg::ST_P_RD0;
			hcb_pkg::ST_MERGE:  state_d = hcb_pkg::ST_SW_RD;
			hcb_pkg::ST_W_RD0:  state_d = hcb_pkg::ST_W_ROOT;
			hcb_pkg::ST_W_ROOT: state_d = hcb_pkg::ST_W_POP;
			hcb_pkg::ST_W_POP:
				state_d = sts.sp_zero ? hcb_pkg::ST_B_DONE : hcb_pkg::ST_W_EXAM;
			hcb_pkg::ST_W_EXAM:
				state_d = sts.is_leaf ? hcb_pkg::ST_W_POP : hcb_pkg::ST_W_ONE;
			hcb_pkg::ST_W_ONE:  state_d = hcb_pkg::ST_W_ZERO;
			hcb_pkg::ST_W_ZERO: state_d = hcb_pkg::ST_W_POP;
			hcb_pkg::ST_B_DONE: state_d = hcb_pkg::ST_IDLE;
			default:            state_d = hcb_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.in_ready = (state_q == hcb_pkg::ST_IDLE);
		cmd.op       = hcb_pkg::OP_NONE;
		case (state_q)
			hcb_pkg::ST_CNT_RD:    cmd.op = hcb_pkg::OP_CNT_RD;
			hcb_pkg::ST_CNT_WR:    cmd.op = hcb_pkg::OP_CNT_WR;
			hcb_pkg::ST_ENC_RD:    cmd.op = hcb_pkg::OP_ENC_RD;
			hcb_pkg::ST_ENC_OUT:
				cmd.op = sts.out_full ? hcb_pkg::OP_NONE : hcb_pkg::OP_ENC_OUT;
			hcb_pkg::ST_B_INIT:    cmd.op = hcb_pkg::OP_B_INIT;
			hcb_pkg::ST_SCAN_RD:   cmd.op = hcb_pkg::OP_SCAN_RD;
			hcb_pkg::ST_SCAN_CHK:
				cmd.op = sts.cnt_nz ? hcb_pkg::OP_SCAN_PUSH : hcb_pkg::OP_NONE;
			hcb_pkg::ST_SCAN_NEXT: cmd.op = hcb_pkg::OP_SCAN_NEXT;
			hcb_pkg::ST_SW_RD:
				cmd.op = sts.idx_zero ? hcb_pkg::OP_SW_PUT : hcb_pkg::OP_SW_RD;
			hcb_pkg::ST_SW_CMP:
				cmd.op = sts.sw_up ? hcb_pkg::OP_SW_MOVE : hcb_pkg::OP_SW_PUT;
			hcb_pkg::ST_P_RD0:     cmd.op = hcb_pkg::OP_P_RD0;
			hcb_pkg::ST_P_RDL:     cmd.op = hcb_pkg::OP_P_RDL;
			hcb_pkg::ST_P_CAP:     cmd.op = hcb_pkg::OP_P_CAP;
			hcb_pkg::ST_SK_RL:     cmd.op = hcb_pkg::OP_SK_RL;
			hcb_pkg::ST_SK_RR:     cmd.op = hcb_pkg::OP_SK_RR;
			hcb_pkg::ST_SK_STEP:   cmd.op = hcb_pkg::OP_SK_STEP;
			hcb_pkg::ST_SAVE_A:    cmd.op = hcb_pkg::OP_SAVE_A;
			hcb_pkg::ST_MERGE:     cmd.op = hcb_pkg::OP_MERGE;
			hcb_pkg::ST_W_RD0:     cmd.op = hcb_pkg::OP_W_RD0;
			hcb_pkg::ST_W_ROOT:    cmd.op = hcb_pkg::OP_W_ROOT;
			hcb_pkg::ST_W_POP:
				cmd.op = sts.sp_zero ? hcb_pkg::OP_NONE : hcb_pkg::OP_W_POP;
			hcb_pkg::ST_W_EXAM:    cmd.op = hcb_pkg::OP_W_EXAM;
			hcb_pkg::ST_W_ONE:     cmd.op = hcb_pkg::OP_W_ONE;
			hcb_pkg::ST_W_ZERO:    cmd.op = hcb_pkg::OP_W_ZERO;
			hcb_pkg::ST_B_DONE:    cmd.op = hcb_pkg::OP_B_DONE;
			default:               cmd.op = hcb_pkg::OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/hcb_dp.sv =====
// hcb_dp: histogram, heap, link, walk stack and code table memories with their registers
// depends on hcb_pkg; driven by hcb_ctrl commands
`default_nettype none
module hcb_dp #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS    = 24,
	parameter int MAX_CODE_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hcb_pkg::cmd_t cmd,
	output hcb_pkg::sts_t      sts,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_mode,
	input  wire logic [7:0]    in_symbol,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        out_code_bits,
	output logic [5:0]         out_code_length,
	output logic [1:0]         out_error
);

	localparam int SB = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int NB = $clog2(2 * ALPHABET_SIZE - 1);
	localparam int FB = $clog2(ALPHABET_SIZE + 1);
	localparam int WB = COUNT_BITS + SB;
	localparam int LB = SB;
	localparam int CW = SB + 2;
	localparam int CB = hcb_pkg::CODE_FIELD_BITS;
	localparam int CODE_LIMIT = (MAX_CODE_BITS < CB) ? MAX_CODE_BITS : CB;

	typedef struct packed {
		logic [NB-1:0] node;
		logic [WB-1:0] w;
	} heap_ent_t;

	typedef struct packed {
		logic [NB-1:0] zero;
		logic [NB-1:0] one;
	} link_ent_t;

	typedef struct packed {
		logic [NB-1:0] node;
		logic [CB-1:0] word;
		logic [LB-1:0] len;
	} stack_ent_t;

	typedef struct packed {
		hcb_pkg::tab_status_t                       st;
		logic [hcb_pkg::LEN_FIELD_BITS-1:0]         len;
		logic [CB-1:0]                              word;
	} tab_ent_t;

	// memories
	logic [COUNT_BITS-1:0] cnt_mem [ALPHABET_SIZE];
	heap_ent_t             heap_mem [ALPHABET_SIZE];
	link_ent_t             link_mem [ALPHABET_SIZE];
	stack_ent_t            stack_mem [ALPHABET_SIZE];
	tab_ent_t              tab_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] cnt_vld_q;
	logic [ALPHABET_SIZE-1:0] tab_vld_q;

	logic [7:0]            sym_q;
	logic [FB-1:0]         fill_q;
	logic [SB-1:0]         idx_q;
	logic [SB-1:0]         s_q;
	logic [NB-1:0]         next_q;
	logic [FB-1:0]         sp_q;
	heap_ent_t             mov_q, top_q, a_q, lch_q, heap_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic                  cnt_rdv_q;
	link_ent_t             link_rd_q;
	stack_ent_t            stack_rd_q, ent_q;
	tab_ent_t              tab_rd_q;
	logic                  tab_rdv_q;
	logic                  out_valid_q;
	logic [31:0]           out_bits_q;
	logic [5:0]            out_len_q;
	logic [1:0]            out_err_q;

	logic                  sym_ok;
	logic [COUNT_BITS-1:0] cnt_val;
	logic [CW-1:0]         l_idx, r_idx;
	logic                  l_ok, r_ok;
	logic [SB-1:0]         parent;
	logic                  pick_l, pick_r;
	logic [WB-1:0]         best_w;
	logic [SB-1:0]         cnt_raddr;
	logic                  cnt_ren;
	logic [SB-1:0]         heap_raddr;
	logic                  heap_ren;
	logic                  heap_wen;
	logic [SB-1:0]         heap_waddr;
	heap_ent_t             heap_wdata;
	logic                  stack_wen;
	logic [SB-1:0]         stack_waddr;
	stack_ent_t            stack_wdata;
	logic [FB-1:0]         sp_m1;
	logic                  leaf_now;
	logic                  out_full;

	// index arithmetic and compares
	assign sym_ok  = ({1'b0, sym_q} < 9'(ALPHABET_SIZE));
	assign cnt_val = cnt_rdv_q ? cnt_rd_q : '0;
	assign l_idx   = {1'b0, idx_q, 1'b0} + CW'(1);
	assign r_idx   = {1'b0, idx_q, 1'b0} + CW'(2);
	assign l_ok    = l_idx < CW'(fill_q);
	assign r_ok    = r_idx < CW'(fill_q);
	assign parent  = SB'((idx_q - SB'(1)) >> 1);
	assign sp_m1   = sp_q - FB'(1);
	assign leaf_now = stack_rd_q.node < NB'(ALPHABET_SIZE);
	assign out_full = out_valid_q && !out_ready;

	// sink choice, left child tested first, strict compares
	always_comb begin
		pick_l = l_ok && (lch_q.w < mov_q.w);
		best_w = pick_l ? lch_q.w : mov_q.w;
		pick_r = r_ok && (heap_rd_q.w < best_w);
	end

	// status to controller
	always_comb begin
		sts.in_fire   = in_valid && cmd.in_ready;
		sts.in_mode   = in_mode;
		sts.cnt_nz    = (cnt_val != '0);
		sts.scan_last = (s_q == SB'(ALPHABET_SIZE - 1));
		sts.idx_zero  = (idx_q == '0);
		sts.sw_up     = (heap_rd_q.w > mov_q.w);
		sts.sk_move   = pick_l || pick_r;
		sts.fill_gt1  = (fill_q > FB'(1));
		sts.fill_zero = (fill_q == '0);
		sts.sp_zero   = (sp_q == '0);
		sts.is_leaf   = leaf_now;
		sts.out_full  = out_full;
	end

	// memory address selection
	always_comb begin
		cnt_ren    = (cmd.op == hcb_pkg::OP_CNT_RD) || (cmd.op == hcb_pkg::OP_SCAN_RD);
		cnt_raddr  = (cmd.op == hcb_pkg::OP_SCAN_RD) ? s_q : sym_q[SB-1:0];
		heap_ren   = 1'b1;
		heap_raddr = '0;
		case (cmd.op)
			hcb_pkg::OP_SW_RD: heap_raddr = parent;
			hcb_pkg::OP_P_RDL: heap_raddr = SB'(fill_q - FB'(1));
			hcb_pkg::OP_SK_RL: heap_raddr = l_idx[SB-1:0];
			hcb_pkg::OP_SK_RR: heap_raddr = r_idx[SB-1:0];
			hcb_pkg::OP_P_RD0, hcb_pkg::OP_W_RD0: heap_raddr = '0;
			default: heap_ren = 1'b0;
		endcase
		heap_wen   = 1'b0;
		heap_waddr = idx_q;
		heap_wdata = mov_q;
		case (cmd.op)
			hcb_pkg::OP_SW_PUT: heap_wen = 1'b1;
			hcb_pkg::OP_SW_MOVE: begin
				heap_wen   = 1'b1;
				heap_wdata = heap_rd_q;
			end
			hcb_pkg::OP_SK_STEP: begin
				heap_wen = 1'b1;
				if (pick_r)
					heap_wdata = heap_rd_q;
				else if (pick_l)
					heap_wdata = lch_q;
				else
					heap_wdata = mov_q;
			end
			default: heap_wen = 1'b0;
		endcase
		stack_wen   = 1'b0;
		stack_waddr = sp_q[SB-1:0];
		stack_wdata = ent_q;
		case (cmd.op)
			hcb_pkg::OP_W_ROOT: begin
				stack_wen   = 1'b1;
				stack_waddr = '0;
				stack_wdata = '{node: heap_rd_q.node, word: '0, len: '0};
			end
			hcb_pkg::OP_W_ONE: begin
				stack_wen   = 1'b1;
				stack_wdata = '{node: link_rd_q.one, word: {ent_q.word[CB-2:0], 1'b1},
					len: ent_q.len + LB'(1)};
			end
			hcb_pkg::OP_W_ZERO: begin
				stack_wen   = 1'b1;
				stack_wdata = '{node: link_rd_q.zero, word: {ent_q.word[CB-2:0], 1'b0},
					len: ent_q.len + LB'(1)};
			end
			default: stack_wen = 1'b0;
		endcase
	end

	// histogram memory
	always_ff @(posedge clk) begin
		if (cnt_ren) cnt_rd_q <= cnt_mem[cnt_raddr];
		if (cmd.op == hcb_pkg::OP_CNT_WR && sym_ok)
			cnt_mem[sym_q[SB-1:0]] <= (cnt_val == '1) ? cnt_val : cnt_val + COUNT_BITS'(1);
	end

	// heap memory
	always_ff @(posedge clk) begin
		if (heap_ren) heap_rd_q <= heap_mem[heap_raddr];
		if (heap_wen) heap_mem[heap_waddr] <= heap_wdata;
	end

	// tree link memory
	always_ff @(posedge clk) begin
		if (cmd.op == hcb_pkg::OP_W_EXAM && !leaf_now)
			link_rd_q <= link_mem[SB'(stack_rd_q.node - NB'(ALPHABET_SIZE))];
		if (cmd.op == hcb_pkg::OP_MERGE)
			link_mem[SB'(next_q - NB'(ALPHABET_SIZE))] <= '{zero: a_q.node, one: top_q.node};
	end

	// walk stack memory
	always_ff @(posedge clk) begin
		if (cmd.op == hcb_pkg::OP_W_POP) stack_rd_q <= stack_mem[sp_m1[SB-1:0]];
		if (stack_wen) stack_mem[stack_waddr] <= stack_wdata;
	end

	// code table memory
	always_ff @(posedge clk) begin
		if (cmd.op == hcb_pkg::OP_ENC_RD) tab_rd_q <= tab_mem[sym_q[SB-1:0]];
		if (cmd.op == hcb_pkg::OP_W_EXAM && leaf_now) begin
			if (32'(stack_rd_q.len) > 32'(CODE_LIMIT))
				tab_mem[stack_rd_q.node[SB-1:0]] <= '{st: hcb_pkg::TS_LONG, len: '0,
					word: '0};
			else
				tab_mem[stack_rd_q.node[SB-1:0]] <= '{st: hcb_pkg::TS_OK,
					len: hcb_pkg::LEN_FIELD_BITS'(stack_rd_q.len), word: stack_rd_q.word};
		end
	end

	// valid bits for histogram and code table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q   <= '0;
			tab_vld_q   <= '0;
			cnt_rdv_q   <= 1'b0;
			tab_rdv_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cnt_ren) cnt_rdv_q <= cnt_vld_q[cnt_raddr];
			if (cmd.op == hcb_pkg::OP_CNT_WR && sym_ok) cnt_vld_q[sym_q[SB-1:0]] <= 1'b1;
			if (cmd.op == hcb_pkg::OP_B_DONE) cnt_vld_q <= '0;
			if (cmd.op == hcb_pkg::OP_ENC_RD)
				tab_rdv_q <= tab_vld_q[sym_q[SB-1:0]] && sym_ok;
			if (cmd.op == hcb_pkg::OP_B_INIT) tab_vld_q <= '0;
			if (cmd.op == hcb_pkg::OP_W_EXAM && leaf_now)
				tab_vld_q[stack_rd_q.node[SB-1:0]] <= 1'b1;
			if (cmd.op == hcb_pkg::OP_ENC_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// build control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sp_q   <= '0;
		end else begin
			case (cmd.op)
				hcb_pkg::OP_B_INIT:    fill_q <= '0;
				hcb_pkg::OP_SCAN_PUSH: fill_q <= fill_q + FB'(1);
				hcb_pkg::OP_MERGE:     fill_q <= fill_q + FB'(1);
				hcb_pkg::OP_P_RDL:     fill_q <= fill_q - FB'(1);
				hcb_pkg::OP_W_ROOT:    sp_q <= FB'(1);
				hcb_pkg::OP_W_POP:     sp_q <= sp_m1;
				hcb_pkg::OP_W_ONE:     sp_q <= sp_q + FB'(1);
				hcb_pkg::OP_W_ZERO:    sp_q <= sp_q + FB'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && cmd.in_ready) sym_q <= in_symbol;
		case (cmd.op)
			hcb_pkg::OP_B_INIT: begin
				s_q    <= '0;
				next_q <= NB'(ALPHABET_SIZE);
			end
			hcb_pkg::OP_SCAN_PUSH: begin
				mov_q <= '{node: NB'(s_q), w: WB'(cnt_val)};
				idx_q <= SB'(fill_q);
			end
			hcb_pkg::OP_SCAN_NEXT: s_q <= s_q + SB'(1);
			hcb_pkg::OP_SW_MOVE:   idx_q <= parent;
			hcb_pkg::OP_P_RDL:     top_q <= heap_rd_q;
			hcb_pkg::OP_P_CAP: begin
				mov_q <= heap_rd_q;
				idx_q <= '0;
			end
			hcb_pkg::OP_SK_RR:     lch_q <= heap_rd_q;
			hcb_pkg::OP_SK_STEP: begin
				if (pick_r)
					idx_q <= r_idx[SB-1:0];
				else if (pick_l)
					idx_q <= l_idx[SB-1:0];
			end
			hcb_pkg::OP_SAVE_A:    a_q <= top_q;
			hcb_pkg::OP_MERGE: begin
				mov_q  <= '{node: next_q, w: a_q.w + top_q.w};
				idx_q  <= SB'(fill_q);
				next_q <= next_q + NB'(1);
			end
			hcb_pkg::OP_W_EXAM:    ent_q <= stack_rd_q;
			hcb_pkg::OP_ENC_OUT: begin
				out_bits_q <= '0;
				out_len_q  <= '0;
				out_err_q  <= hcb_pkg::ERR_NO_CODE;
				if (tab_rdv_q) begin
					case (tab_rd_q.st)
						hcb_pkg::TS_OK: begin
							out_bits_q <= tab_rd_q.word;
							out_len_q  <= tab_rd_q.len;
							out_err_q  <= hcb_pkg::ERR_OK;
						end
						hcb_pkg::TS_LONG: out_err_q <= hcb_pkg::ERR_TOO_LONG;
						default:          out_err_q <= hcb_pkg::ERR_NO_CODE;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_code_bits   = out_bits_q;
	assign out_code_length = out_len_q;
	assign out_error       = out_err_q;

endmodule
`default_nettype wire

// ===== rtl/huffman_code_builder_encoder.sv =====
// count request: ready only while idle, so the next count is taken only after CNT_RD and CNT_WR
// encode request: table read in ENC_RD, result registered in ENC_OUT, which waits while out stalls
// build request: a histogram scan pushes each nonzero count into the heap, SW_RD and SW_CMP per
//   heap level; a pop runs P_RD0, P_RDL, P_CAP, then SK_RL, SK_RR and SK_STEP per level; the walk
//   pops and examines each node and pushes both children of a merged node; one heap memory port sets the pace
// arst_n clears histogram and code table valid bits at once, so no clearing pass is needed
`default_nettype none
module huffman_code_builder_encoder #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS    = 24,
	parameter int MAX_CODE_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	hcb_in_if.sink    in_ch,
	hcb_out_if.source out_ch
);

	hcb_pkg::cmd_t cmd;
	hcb_pkg::sts_t sts;

	assign in_ch.ready = cmd.in_ready;

	// sequencer
	hcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// memories and registers
	hcb_dp #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COUNT_BITS    (COUNT_BITS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_valid        (in_ch.valid),
		.in_mode         (in_ch.mode),
		.in_symbol       (in_ch.symbol),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_code_bits   (out_ch.code_bits),
		.out_code_length (out_ch.code_length),
		.out_error       (out_ch.error)
	);

endmodule
`default_nettype wire

// ===== rtl/hcb_checker.sv =====
// hcb_checker: port level assertions for the huffman code builder/encoder
// depends on hcb_pkg; bound to huffman_code_builder_encoder below
`default_nettype none
module hcb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  in_mode,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] code_bits,
	input wire logic [5:0]  code_length,
	input wire logic [1:0]  error
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_bits) && $stable(error))
		else $error("stalled result changed");

	// error results carry no code
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != hcb_pkg::ERR_OK |-> code_bits == '0 && code_length == '0)
		else $error("error result with code");

	// code length within the field
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error == hcb_pkg::ERR_OK |-> code_length <= 6'd32)
		else $error("code length too large");

	// error code is a defined one
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error == hcb_pkg::ERR_OK || error == hcb_pkg::ERR_NO_CODE ||
			error == hcb_pkg::ERR_TOO_LONG)
		else $error("undefined error code");

	// one request at a time for every defined mode
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == hcb_pkg::MODE_COUNT ||
			in_mode == hcb_pkg::MODE_BUILD || in_mode == hcb_pkg::MODE_ENCODE)
		|=> !in_ready)
		else $error("request taken while busy");

endmodule

bind huffman_code_builder_encoder hcb_checker u_hcb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_mode     (in_ch.mode),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.code_bits   (out_ch.code_bits),
	.code_length (out_ch.code_length),
	.error       (out_ch.error)
);
`default_nettype wire
